@@ rtl/ftrg_pkg.sv @@
`timescale 1ns / 1ps
// Package for the frame time resolution governor: field widths, limits,
// reset values, band and register codes, shared structs and clamp functions.
// No dependencies.
package ftrg_pkg;

	localparam int SCALE_W    = 11;
	localparam int TIME_W     = 16;
	localparam int STEP_W     = 9;
	localparam int TARGET_W   = 10;
	localparam int BAND_W     = 8;
	localparam int UPPER_W    = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [SCALE_W-1:0]  SCALE_LO   = 11'd256;
	localparam logic [SCALE_W-1:0]  SCALE_HI   = 11'd1024;
	localparam logic [STEP_W-1:0]   STEP_LO    = 9'd13;
	localparam logic [STEP_W-1:0]   STEP_HI    = 9'd256;
	localparam logic [TARGET_W-1:0] TARGET_LO  = 10'd128;
	localparam logic [TARGET_W-1:0] TARGET_HI  = 10'd800;
	localparam logic [BAND_W-1:0]   BAND_LO    = 8'd8;
	localparam logic [BAND_W-1:0]   BAND_HI    = 8'd160;
	localparam logic [TARGET_W-1:0] FLOOR_TIME = 10'd16;

	localparam logic                GOV_ON_RST = 1'b1;
	localparam logic [SCALE_W-1:0]  MIN_RST    = 11'd384;
	localparam logic [SCALE_W-1:0]  MAX_RST    = 11'd768;
	localparam logic [STEP_W-1:0]   STEP_RST   = 9'd64;
	localparam logic [TARGET_W-1:0] TARGET_RST = 10'd266;
	localparam logic [BAND_W-1:0]   BAND_RST   = 8'd32;
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 11'd768;

	localparam int DOWN_TRIGGER_DEF = 3;
	localparam int UP_TRIGGER_DEF   = 30;

	typedef enum logic [1:0] {
		BAND_OVER    = 2'd0,
		BAND_UNDER   = 2'd1,
		BAND_WITHIN  = 2'd2,
		BAND_IGNORED = 2'd3
	} band_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GOVERNOR_ON = 3'd0,
		REG_MIN_SCALE   = 3'd1,
		REG_MAX_SCALE   = 3'd2,
		REG_SCALE_STEP  = 3'd3,
		REG_TARGET_TIME = 3'd4,
		REG_BAND_WIDTH  = 3'd5
	} reg_idx_t;

	// Effective settings as the item path uses them.
	typedef struct packed {
		logic                gov_on;
		logic [SCALE_W-1:0]  eff_min;
		logic [SCALE_W-1:0]  eff_max;
		logic [STEP_W-1:0]   step;
		logic [UPPER_W-1:0]  upper;
		logic [TARGET_W-1:0] lower;
	} cfg_view_t;

	// Side effects of a register write on the governor state.
	typedef struct packed {
		logic               gov_toggle;
		logic               gov_off;
		logic               rescale;
		logic [SCALE_W-1:0] eff_min_nx;
		logic [SCALE_W-1:0] eff_max_nx;
	} cfg_evt_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic               scale_changed;
		band_t              band;
	} result_t;

	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v,
		input logic [SCALE_W-1:0] lo, input logic [SCALE_W-1:0] hi);
		if (v < lo) begin
			return lo;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic logic [STEP_W-1:0] clamp_step(input logic [STEP_W-1:0] v);
		if (v < STEP_LO) begin
			return STEP_LO;
		end else if (v > STEP_HI) begin
			return STEP_HI;
		end
		return v;
	endfunction

	function automatic logic [TARGET_W-1:0] clamp_target(input logic [TARGET_W-1:0] v);
		if (v < TARGET_LO) begin
			return TARGET_LO;
		end else if (v > TARGET_HI) begin
			return TARGET_HI;
		end
		return v;
	endfunction

	function automatic logic [BAND_W-1:0] clamp_band(input logic [BAND_W-1:0] v);
		if (v < BAND_LO) begin
			return BAND_LO;
		end else if (v > BAND_HI) begin
			return BAND_HI;
		end
		return v;
	endfunction

endpackage

@@ rtl/ftrg_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the governor: frame input, result output
// and register write. Depends on ftrg_pkg.
interface ftrg_frame_if import ftrg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] frame_time;
	logic              power_save;

	modport source (output valid, output frame_time, output power_save, input ready);
	modport sink (input valid, input frame_time, input power_save, output ready);
endinterface

interface ftrg_result_if import ftrg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCALE_W-1:0] scale;
	logic               scale_changed;
	band_t              band;

	modport source (output valid, output scale, output scale_changed, output band, input ready);
	modport sink (input valid, input scale, input scale_changed, input band, output ready);
endinterface

interface ftrg_cfg_if import ftrg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/frame_time_resolution_governor_unit.sv @@
`timescale 1ns / 1ps
// Top level of the frame time resolution governor: register file, state update
// and result buffer. Depends on ftrg_pkg, ftrg_if, ftrg_cfg, ftrg_core, ftrg_out_buf.
//
//   Port        Direction  Carries
//   frame_in    sink       frame_time, power_save
//   result_out  source     scale, scale_changed, band
//   cfg         sink       index, data (register write)
//
// A frame is classified and the scale updated in the cycle of its transfer; the
// result is registered in the two-entry buffer before result_out shows it, and
// one frame per cycle is sustained while it has room: frame_in.ready falls only
// when both entries hold results not yet taken. cfg is always ready.
// arst_n restores the register reset values, scale 768 and clear streaks.
module frame_time_resolution_governor_unit import ftrg_pkg::*; #(
	parameter int DOWN_TRIGGER = DOWN_TRIGGER_DEF,
	parameter int UP_TRIGGER   = UP_TRIGGER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ftrg_frame_if.sink    frame_in,
	ftrg_result_if.source result_out,
	ftrg_cfg_if.sink      cfg
);

	cfg_view_t view;
	cfg_evt_t  evt;
	result_t   res;
	logic      take;
	logic      buf_ready;

	assign frame_in.ready = buf_ready;
	assign take           = frame_in.valid && buf_ready;

	ftrg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.view   (view),
		.evt    (evt)
	);

	ftrg_core #(
		.DOWN_TRIGGER (DOWN_TRIGGER),
		.UP_TRIGGER   (UP_TRIGGER)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.view       (view),
		.evt        (evt),
		.take       (take),
		.frame_time (frame_in.frame_time),
		.power_save (frame_in.power_save),
		.res        (res)
	);

	ftrg_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.push_data  (res),
		.push_ready (buf_ready),
		.out        (result_out)
	);

endmodule

@@ rtl/ftrg_cfg.sv @@
`timescale 1ns / 1ps
// Register file of the governor with the derived effective settings and the
// write side effects on scale and streaks. Depends on ftrg_pkg and ftrg_if.
module ftrg_cfg import ftrg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ftrg_cfg_if.sink   cfg,
	output cfg_view_t  view,
	output cfg_evt_t   evt
);

	typedef struct packed {
		logic                gov_on;
		logic [SCALE_W-1:0]  min_scale;
		logic [SCALE_W-1:0]  max_scale;
		logic [STEP_W-1:0]   step;
		logic [TARGET_W-1:0] target;
		logic [BAND_W-1:0]   band;
	} raw_t;

	function automatic cfg_view_t make_view(input raw_t r);
		cfg_view_t             v;
		logic [TARGET_W-1:0]   tgt;
		logic [BAND_W-1:0]     hys;
		v.gov_on  = r.gov_on;
		v.eff_min = clamp_scale(r.min_scale, SCALE_LO, SCALE_HI);
		v.eff_max = clamp_scale(r.max_scale, v.eff_min, SCALE_HI);
		v.step    = clamp_step(r.step);
		tgt       = clamp_target(r.target);
		hys       = clamp_band(r.band);
		v.upper   = {1'b0, tgt} + {{(UPPER_W-BAND_W){1'b0}}, hys};
		if ({1'b0, tgt} < ({{(UPPER_W-BAND_W){1'b0}}, hys} + {1'b0, FLOOR_TIME})) begin
			v.lower = FLOOR_TIME;
		end else begin
			v.lower = tgt - {{(TARGET_W-BAND_W){1'b0}}, hys};
		end
		return v;
	endfunction

	raw_t      raw_q;
	raw_t      raw_nx;
	cfg_view_t view_nx;
	logic      wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	always_comb begin
		raw_nx = raw_q;
		if (wr) begin
			case (cfg.index)
				REG_GOVERNOR_ON: raw_nx.gov_on    = cfg.data[0];
				REG_MIN_SCALE:   raw_nx.min_scale = cfg.data[SCALE_W-1:0];
				REG_MAX_SCALE:   raw_nx.max_scale = cfg.data[SCALE_W-1:0];
				REG_SCALE_STEP:  raw_nx.step      = cfg.data[STEP_W-1:0];
				REG_TARGET_TIME: raw_nx.target    = cfg.data[TARGET_W-1:0];
				REG_BAND_WIDTH:  raw_nx.band      = cfg.data[BAND_W-1:0];
				default: ;
			endcase
		end
		view_nx = make_view(raw_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q.gov_on    <= GOV_ON_RST;
			raw_q.min_scale <= MIN_RST;
			raw_q.max_scale <= MAX_RST;
			raw_q.step      <= STEP_RST;
			raw_q.target    <= TARGET_RST;
			raw_q.band      <= BAND_RST;
		end else begin
			raw_q <= raw_nx;
		end
	end

	assign view           = make_view(raw_q);
	assign evt.gov_toggle = raw_nx.gov_on != raw_q.gov_on;
	assign evt.gov_off    = (raw_nx.gov_on != raw_q.gov_on) && !raw_nx.gov_on;
	assign evt.rescale    = wr && ((cfg.index == REG_MIN_SCALE) || (cfg.index == REG_MAX_SCALE));
	assign evt.eff_min_nx = view_nx.eff_min;
	assign evt.eff_max_nx = view_nx.eff_max;

endmodule

@@ rtl/ftrg_core.sv @@
`timescale 1ns / 1ps
// Governor state (scale and the two streak counters) and the combinational
// classification and scale update for one frame. Depends on ftrg_pkg.
module ftrg_core import ftrg_pkg::*; #(
	parameter int DOWN_TRIGGER = DOWN_TRIGGER_DEF,
	parameter int UP_TRIGGER   = UP_TRIGGER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_view_t         view,
	input  cfg_evt_t          evt,
	input  logic              take,
	input  logic [TIME_W-1:0] frame_time,
	input  logic              power_save,
	output result_t           res
);

	localparam int OVER_W  = $clog2(DOWN_TRIGGER + 1);
	localparam int UNDER_W = $clog2(UP_TRIGGER + 1);
	localparam logic [OVER_W:0]  DOWN_LIM = (OVER_W+1)'(DOWN_TRIGGER);
	localparam logic [UNDER_W:0] UP_LIM   = (UNDER_W+1)'(UP_TRIGGER);

	logic [SCALE_W-1:0] scale_q;
	logic [OVER_W-1:0]  over_q;
	logic [UNDER_W-1:0] under_q;

	logic [SCALE_W-1:0] scale_nx;
	logic [OVER_W-1:0]  over_nx;
	logic [UNDER_W-1:0] under_nx;
	logic [OVER_W:0]    over_inc;
	logic [UNDER_W:0]   under_inc;
	logic [SCALE_W:0]   scale_dn;
	logic [SCALE_W:0]   scale_up;
	logic               ignored;
	band_t              band;

	function automatic logic [SCALE_W-1:0] clamp_wide(input logic [SCALE_W:0] v,
		input logic [SCALE_W-1:0] lo, input logic [SCALE_W-1:0] hi);
		if (v < {1'b0, lo}) begin
			return lo;
		end else if (v > {1'b0, hi}) begin
			return hi;
		end
		return v[SCALE_W-1:0];
	endfunction

	always_comb begin
		ignored   = !view.gov_on || power_save || (frame_time == '0);
		over_inc  = {1'b0, over_q} + 1'b1;
		under_inc = {1'b0, under_q} + 1'b1;
		scale_dn  = {1'b0, scale_q} - {{(SCALE_W+1-STEP_W){1'b0}}, view.step};
		scale_up  = {1'b0, scale_q} + {{(SCALE_W+1-STEP_W){1'b0}}, view.step};
		scale_nx  = scale_q;
		over_nx   = over_q;
		under_nx  = under_q;
		band      = BAND_IGNORED;
		if (power_save) begin
			over_nx  = '0;
			under_nx = '0;
		end
		if (!ignored) begin
			if (frame_time > {{(TIME_W-UPPER_W){1'b0}}, view.upper}) begin
				band     = BAND_OVER;
				under_nx = '0;
				if (over_inc >= DOWN_LIM) begin
					over_nx  = '0;
					scale_nx = clamp_wide(scale_dn, view.eff_min, view.eff_max);
				end else begin
					over_nx = over_inc[OVER_W-1:0];
				end
			end else if (frame_time < {{(TIME_W-TARGET_W){1'b0}}, view.lower}) begin
				band    = BAND_UNDER;
				over_nx = '0;
				if (under_inc >= UP_LIM) begin
					under_nx = '0;
					scale_nx = clamp_wide(scale_up, view.eff_min, view.eff_max);
				end else begin
					under_nx = under_inc[UNDER_W-1:0];
				end
			end else begin
				band     = BAND_WITHIN;
				over_nx  = '0;
				under_nx = '0;
			end
		end
	end

	assign res.scale         = scale_nx;
	assign res.scale_changed = scale_nx != scale_q;
	assign res.band          = band;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			over_q  <= '0;
			under_q <= '0;
		end else if (take) begin
			scale_q <= scale_nx;
			over_q  <= over_nx;
			under_q <= under_nx;
		end else begin
			if (evt.gov_toggle) begin
				over_q  <= '0;
				under_q <= '0;
			end
			if (evt.gov_off) begin
				scale_q <= evt.eff_max_nx;
			end else if (evt.rescale) begin
				scale_q <= clamp_scale(scale_q, evt.eff_min_nx, evt.eff_max_nx);
			end
		end
	end

endmodule

@@ rtl/ftrg_out_buf.sv @@
`timescale 1ns / 1ps
// Two-entry result buffer: an output register plus a skid register, so a new
// frame is taken while a result waits. Depends on ftrg_pkg and ftrg_if.
module ftrg_out_buf import ftrg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  result_t       push_data,
	output logic          push_ready,
	ftrg_result_if.source out
);

	result_t    head_q;
	result_t    tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop               = out.valid && out.ready;
	assign push_ready        = cnt_q != 2'd2;
	assign out.valid         = cnt_q != 2'd0;
	assign out.scale         = head_q.scale;
	assign out.scale_changed = head_q.scale_changed;
	assign out.band          = head_q.band;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end
	end

endmodule

@@ test/tb_frame_time_resolution_governor_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for frame_time_resolution_governor_unit: frames and register writes
// go in over valid/ready channels and every result is checked against a local governor model.
// Depends on ftrg_pkg, the ftrg channel interfaces and the governor RTL.
module tb_frame_time_resolution_governor_unit;
	import ftrg_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_LIMIT   = 50;
	localparam int STREAK_MAX    = 255;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef enum int {FK_OVER, FK_UNDER, FK_WITHIN, FK_ZERO, FK_PSAVE, FK_NOISE} frame_kind_t;
	typedef enum int {CFG_TYPICAL, CFG_LOW_EDGE, CFG_HIGH_EDGE, CFG_WILD} phase_cfg_t;

	typedef struct {
		logic [TIME_W-1:0] frame_time;
		logic              power_save;
	} frame_item_t;

	logic clk = 1'b0;
	logic arst_n;

	always #2 clk = ~clk;

	ftrg_frame_if  frame_ch();
	ftrg_result_if result_ch();
	ftrg_cfg_if    reg_ch();

	frame_time_resolution_governor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_in(frame_ch),
		.result_out(result_ch),
		.cfg(reg_ch)
	);

	logic                gov_on_m;
	logic [SCALE_W-1:0]  min_reg;
	logic [SCALE_W-1:0]  max_reg;
	logic [STEP_W-1:0]   step_reg;
	logic [TARGET_W-1:0] target_reg;
	logic [BAND_W-1:0]   hyst_reg;
	logic [SCALE_W-1:0]  scale_now;
	int                  over_run;
	int                  under_run;

	frame_item_t pending_frames[$];
	result_t     expected_results[$];
	result_t     oldest_result;

	int frames_queued  = 0;
	int frames_taken   = 0;
	int reg_writes     = 0;
	int results_seen   = 0;
	int scale_moves    = 0;
	int ignored_seen   = 0;
	int mismatches     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	function automatic int bound(input int v, input int lo, input int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic int floor_scale();
		return bound(int'(min_reg), int'(SCALE_LO), int'(SCALE_HI));
	endfunction

	function automatic int ceil_scale();
		return bound(int'(max_reg), floor_scale(), int'(SCALE_HI));
	endfunction

	function automatic int upper_time();
		return bound(int'(target_reg), int'(TARGET_LO), int'(TARGET_HI))
			+ bound(int'(hyst_reg), int'(BAND_LO), int'(BAND_HI));
	endfunction

	function automatic int lower_time();
		int lo_t;
		lo_t = bound(int'(target_reg), int'(TARGET_LO), int'(TARGET_HI))
			- bound(int'(hyst_reg), int'(BAND_LO), int'(BAND_HI));
		if (lo_t < int'(FLOOR_TIME)) begin
			lo_t = int'(FLOOR_TIME);
		end
		return lo_t;
	endfunction

	function automatic void restore_power_on_state();
		gov_on_m   = GOV_ON_RST;
		min_reg    = MIN_RST;
		max_reg    = MAX_RST;
		step_reg   = STEP_RST;
		target_reg = TARGET_RST;
		hyst_reg   = BAND_RST;
		scale_now  = SCALE_RST;
		over_run   = 0;
		under_run  = 0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_GOVERNOR_ON: begin
				if (val[0] != gov_on_m) begin
					gov_on_m  = val[0];
					over_run  = 0;
					under_run = 0;
					if (!val[0]) begin
						scale_now = SCALE_W'(ceil_scale());
					end
				end
			end
			REG_MIN_SCALE: begin
				min_reg   = val[SCALE_W-1:0];
				scale_now = SCALE_W'(bound(int'(scale_now), floor_scale(), ceil_scale()));
			end
			REG_MAX_SCALE: begin
				max_reg   = val[SCALE_W-1:0];
				scale_now = SCALE_W'(bound(int'(scale_now), floor_scale(), ceil_scale()));
			end
			REG_SCALE_STEP:  step_reg = val[STEP_W-1:0];
			REG_TARGET_TIME: target_reg = val[TARGET_W-1:0];
			REG_BAND_WIDTH:  hyst_reg = val[BAND_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic result_t governor_step(input logic [TIME_W-1:0] ft, input logic ps);
		result_t r;
		int      prev;
		int      stride;
		prev   = int'(scale_now);
		stride = bound(int'(step_reg), int'(STEP_LO), int'(STEP_HI));
		if (ps) begin
			over_run  = 0;
			under_run = 0;
		end
		if (!gov_on_m || ps || ft == '0) begin
			r.band = BAND_IGNORED;
		end else begin
			if (int'(ft) > upper_time()) begin
				r.band = BAND_OVER;
				if (over_run < STREAK_MAX) begin
					over_run = over_run + 1;
				end
				under_run = 0;
			end else if (int'(ft) < lower_time()) begin
				r.band = BAND_UNDER;
				if (under_run < STREAK_MAX) begin
					under_run = under_run + 1;
				end
				over_run = 0;
			end else begin
				r.band    = BAND_WITHIN;
				over_run  = 0;
				under_run = 0;
			end
			if (r.band != BAND_WITHIN) begin
				// The downward adjustment wins when both streaks are due.
				if (over_run >= DOWN_TRIGGER_DEF) begin
					scale_now = SCALE_W'(bound(int'(scale_now) - stride, floor_scale(),
						ceil_scale()));
					over_run  = 0;
				end else if (under_run >= UP_TRIGGER_DEF) begin
					scale_now = SCALE_W'(bound(int'(scale_now) + stride, floor_scale(),
						ceil_scale()));
					under_run = 0;
				end
			end
		end
		r.scale         = scale_now;
		r.scale_changed = (int'(scale_now) != prev);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	task automatic push_frame(input logic [TIME_W-1:0] ft, input logic ps);
		frame_item_t it;
		it.frame_time = ft;
		it.power_save = ps;
		pending_frames.push_back(it);
		frames_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= val;
		@(posedge clk);
		while (!reg_ch.ready) begin
			@(posedge clk);
		end
		apply_reg(idx, val);
		reg_writes++;
		reg_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (frames_taken != frames_queued || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic frame_item_t make_frame(input frame_kind_t kind);
		frame_item_t it;
		int          hi_t;
		int          lo_t;
		hi_t          = upper_time();
		lo_t          = lower_time();
		it.power_save = 1'b0;
		case (kind)
			FK_OVER: begin
				if ($urandom_range(7) == 0) begin
					it.frame_time = TIME_W'($urandom_range(65535, hi_t + 1));
				end else begin
					it.frame_time = TIME_W'($urandom_range(hi_t + 40, hi_t + 1));
				end
			end
			FK_UNDER:  it.frame_time = TIME_W'($urandom_range(lo_t - 1, 1));
			FK_WITHIN: it.frame_time = TIME_W'($urandom_range(hi_t, lo_t));
			FK_ZERO:   it.frame_time = '0;
			FK_PSAVE: begin
				it.frame_time = TIME_W'($urandom_range(65535));
				it.power_save = 1'b1;
			end
			default: begin
				it.frame_time = TIME_W'($urandom_range(65535));
				it.power_save = ($urandom_range(7) == 0);
			end
		endcase
		return it;
	endfunction

	// About half of the runs of under-budget frames are long enough to reach the upward trigger.
	task automatic queue_bursts(input int count);
		int          made;
		int          len;
		int          pick;
		frame_kind_t kind;
		frame_item_t it;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				kind = FK_UNDER;
				len  = ($urandom_range(1) == 1) ? $urandom_range(35, 30) : $urandom_range(29, 1);
			end else if (pick < 75) begin
				kind = FK_OVER;
				len  = $urandom_range(7, 1);
			end else if (pick < 86) begin
				kind = FK_WITHIN;
				len  = $urandom_range(4, 1);
			end else if (pick < 91) begin
				kind = FK_ZERO;
				len  = 1;
			end else if (pick < 96) begin
				kind = FK_PSAVE;
				len  = $urandom_range(2, 1);
			end else begin
				kind = FK_NOISE;
				len  = $urandom_range(3, 1);
			end
			if (len > count - made) begin
				len = count - made;
			end
			repeat (len) begin
				it = make_frame(kind);
				push_frame(it.frame_time, it.power_save);
			end
			made += len;
		end
	endtask

	task automatic configure(input phase_cfg_t mode);
		logic [CFG_DATA_W-1:0] mn;
		logic [CFG_DATA_W-1:0] mx;
		logic [CFG_DATA_W-1:0] st;
		logic [CFG_DATA_W-1:0] tg;
		logic [CFG_DATA_W-1:0] bw;
		case (mode)
			CFG_LOW_EDGE: begin
				mn = SCALE_LO;
				mx = SCALE_HI;
				st = CFG_DATA_W'(STEP_LO);
				tg = CFG_DATA_W'(TARGET_LO);
				bw = CFG_DATA_W'(BAND_LO);
			end
			CFG_HIGH_EDGE: begin
				mn = SCALE_LO;
				mx = SCALE_HI;
				st = CFG_DATA_W'(STEP_HI);
				tg = CFG_DATA_W'(TARGET_HI);
				bw = CFG_DATA_W'(BAND_HI);
			end
			CFG_WILD: begin
				mn = CFG_DATA_W'(($urandom_range(1) == 1) ? $urandom_range(2047)
					: $urandom_range(300));
				mx = CFG_DATA_W'($urandom_range(2047));
				st = CFG_DATA_W'($urandom_range(2047));
				tg = CFG_DATA_W'($urandom_range(2047));
				bw = CFG_DATA_W'($urandom_range(2047));
			end
			default: begin
				mn = CFG_DATA_W'($urandom_range(512, 256));
				mx = CFG_DATA_W'($urandom_range(1024, 640));
				st = CFG_DATA_W'($urandom_range(128, 13));
				tg = CFG_DATA_W'($urandom_range(500, 128));
				bw = CFG_DATA_W'($urandom_range(80, 8));
			end
		endcase
		if ($urandom_range(2) == 0) begin
			write_reg(REG_GOVERNOR_ON, '0);
		end
		write_reg(REG_GOVERNOR_ON, 11'd1);
		write_reg(REG_MAX_SCALE, mx);
		write_reg(REG_MIN_SCALE, mn);
		write_reg(REG_SCALE_STEP, st);
		write_reg(REG_TARGET_TIME, tg);
		write_reg(REG_BAND_WIDTH, bw);
		if ($urandom_range(3) == 0) begin
			write_reg(REG_SPARE_7, CFG_DATA_W'($urandom_range(2047)));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.valid      <= 1'b0;
			frame_ch.frame_time <= '0;
			frame_ch.power_save <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				expected_results.push_back(governor_step(frame_ch.frame_time,
					frame_ch.power_save));
				frames_taken++;
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (pending_frames.size() == 0 || $urandom_range(99) < send_idle_pct) begin
					frame_ch.valid <= 1'b0;
				end else begin
					frame_ch.valid      <= 1'b1;
					frame_ch.frame_time <= pending_frames[0].frame_time;
					frame_ch.power_save <= pending_frames[0].power_save;
					void'(pending_frames.pop_front());
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with none expected: scale %0d",
						result_ch.scale));
				end else begin
					oldest_result = expected_results.pop_front();
					if (result_ch.scale !== oldest_result.scale) begin
						report_mismatch($sformatf("scale %0d, predicted %0d",
							result_ch.scale, oldest_result.scale));
					end
					if (result_ch.scale_changed !== oldest_result.scale_changed) begin
						report_mismatch($sformatf("scale_changed %0b, predicted %0b",
							result_ch.scale_changed, oldest_result.scale_changed));
					end
					if (result_ch.band !== oldest_result.band) begin
						report_mismatch($sformatf("band %0d, predicted %0d",
							result_ch.band, oldest_result.band));
					end
					results_seen++;
					if (oldest_result.scale_changed) begin
						scale_moves++;
					end
					if (oldest_result.band == BAND_IGNORED) begin
						ignored_seen++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("frame_time_resolution_governor_unit regression: fail");
		$finish;
	end

	initial begin
		phase_cfg_t mode;
		arst_n              = 1'b0;
		frame_ch.valid      = 1'b0;
		frame_ch.frame_time = '0;
		frame_ch.power_save = 1'b0;
		result_ch.ready     = 1'b0;
		reg_ch.valid        = 1'b0;
		reg_ch.index        = REG_GOVERNOR_ON;
		reg_ch.data         = '0;
		restore_power_on_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Band edges, field extremes, ignored frames and a streak broken by power save.
		push_frame(16'd298, 1'b0);
		push_frame(16'd234, 1'b0);
		push_frame(16'd299, 1'b0);
		push_frame(16'd65535, 1'b0);
		push_frame(16'd300, 1'b0);
		push_frame(16'd233, 1'b0);
		push_frame(16'd1, 1'b0);
		push_frame(16'd0, 1'b0);
		push_frame(16'd500, 1'b1);
		push_frame(16'd400, 1'b0);
		push_frame(16'd400, 1'b0);
		push_frame(16'd65535, 1'b1);
		push_frame(16'd400, 1'b0);
		push_frame(16'd400, 1'b0);
		push_frame(16'd266, 1'b0);
		push_frame(16'd400, 1'b0);
		push_frame(16'd400, 1'b0);
		push_frame(16'd400, 1'b0);
		wait_idle();
		write_reg(REG_GOVERNOR_ON, '0);
		push_frame(16'd400, 1'b0);
		wait_idle();
		write_reg(REG_GOVERNOR_ON, '0);
		write_reg(REG_GOVERNOR_ON, 11'd1);
		write_reg(REG_SPARE_6, 11'h7ff);
		write_reg(REG_SPARE_7, 11'h555);
		write_reg(REG_MIN_SCALE, 11'd900);
		push_frame(16'd400, 1'b0);
		push_frame(16'd400, 1'b0);
		push_frame(16'd400, 1'b0);
		wait_idle();
		write_reg(REG_MAX_SCALE, 11'h7ff);
		write_reg(REG_MIN_SCALE, '0);
		write_reg(REG_TARGET_TIME, '0);
		write_reg(REG_BAND_WIDTH, 11'd255);
		push_frame(16'd15, 1'b0);
		push_frame(16'd16, 1'b0);
		push_frame(16'd289, 1'b0);
		wait_idle();
		write_reg(REG_TARGET_TIME, 11'd1023);
		write_reg(REG_BAND_WIDTH, '0);
		write_reg(REG_SCALE_STEP, '0);
		push_frame(16'd808, 1'b0);
		push_frame(16'd791, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_idle_pct  = 31;
					recv_stall_pct = 31;
				end
			endcase
			mode = (ph < 4) ? phase_cfg_t'(ph) : CFG_TYPICAL;
			configure(mode);
			queue_bursts(38);
			// The sender holds off here until every outstanding result is back.
			wait_drained();
			queue_bursts(37);
			wait_idle();
		end

		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
		$display("summary: %0d frames and %0d register writes over six idle/stall phases",
			frames_taken, reg_writes);
		$display("summary: %0d results checked, %0d scale adjustments, %0d ignored frames",
			results_seen, scale_moves, ignored_seen);
		if (mismatches == 0) begin
			$display("frame_time_resolution_governor_unit regression: pass");
		end else begin
			$display("frame_time_resolution_governor_unit regression: fail");
		end
		$finish;
	end

endmodule
